### src/glpf_pkg.sv
// ----------------------------------------------------------------------------
// glpf_pkg
// shared sizes, types and register codes of the grid local peak finder
// ----------------------------------------------------------------------------
package glpf_pkg;

    localparam int MAX_ROWS    = 32;
    localparam int MAX_COLS    = 32;
    localparam int PIXEL_WIDTH = 16;

    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [PIXEL_WIDTH-1:0] t_pixel;
    typedef logic [ROW_W-1:0]              t_row;
    typedef logic [COL_W-1:0]              t_col;
    typedef logic [MAX_COLS-1:0]           t_col_mask;
    typedef logic [CFG_W-1:0]              t_cfg;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_ROWS = 0,
        CFG_FRAME_COLS = 1
    } t_cfg_idx;

    // one line store entry: the row above and the row above that
    typedef struct packed {
        t_pixel up;
        t_pixel upup;
    } t_line_entry;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [31:0] size_lim(t_cfg raw, int unsigned lim);
        logic [31:0] v;
        v = 32'(raw);
        if (v == 32'd0) begin
            return 32'd1;
        end
        if (v > lim) begin
            return lim;
        end
        return v;
    endfunction

endpackage

### src/glpf_ram.sv
// ----------------------------------------------------------------------------
// glpf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module glpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/grid_local_peak_finder_top.sv
// ----------------------------------------------------------------------------
// grid_local_peak_finder_top
// 4-neighbour local maxima over a streamed frame of signed pixels
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one per cycle unless o_pixel_stall is high,
// and every pixel that is greater than or equal to its orthogonal neighbours
// inside the frame is reported by row and column in raster order. A pixel
// above the final row is decided in the decision stage, loaded when the pixel
// below it is taken. One line store ram, an entry per column holding the two
// rows above, is read one column ahead and written back on every pixel, which
// sets the rate of one pixel per cycle. Peaks of the final row are kept as a
// column mask; after a frame's last pixel the input stalls while the mask is
// flushed, lowest column first. Writing either size register restarts the frame.
module grid_local_peak_finder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_pixel_valid,
    output logic                                o_pixel_stall,
    input  logic signed [glpf_pkg::PIXEL_WIDTH-1:0] i_pixel_value,
    output logic                                o_peak_valid,
    input  logic                                i_peak_stall,
    output logic [glpf_pkg::ROW_W-1:0]          o_peak_row,
    output logic [glpf_pkg::COL_W-1:0]          o_peak_col,
    output logic                                o_run_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [glpf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [glpf_pkg::CFG_W-1:0]          i_cfg_data
);

    // configuration
    glpf_pkg::t_cfg r_cfg_rows, r_cfg_cols, n_cfg_rows, n_cfg_cols;
    logic [31:0]    rows_lim, cols_lim;
    glpf_pkg::t_row last_row;
    glpf_pkg::t_col last_col;

    // frame position and control
    glpf_pkg::t_row      r_row, n_row;
    glpf_pkg::t_col      r_col, n_col;
    glpf_pkg::t_col      nxt_col;
    logic                r_s_valid, n_s_valid;
    glpf_pkg::t_col_mask r_flags, n_flags;
    logic                r_flushing, n_flushing;
    logic                r_out_valid, n_out_valid;
    logic                r_fwd, n_fwd;

    // output payload
    glpf_pkg::t_row r_out_row, n_out_row;
    glpf_pkg::t_col r_out_col, n_out_col;
    logic           r_out_last, n_out_last;

    // line store access
    glpf_pkg::t_line_entry ram_rd, rd_eff, wr_data, r_fwd_data;

    // pixel history and decision stage
    glpf_pkg::t_pixel r_up_hold, r_prev0, r_prev1;
    glpf_pkg::t_pixel r_s_x, r_s_up, r_s_upup, r_s_upl, r_s_prev0, r_s_prev1;
    glpf_pkg::t_row   r_s_row;
    glpf_pkg::t_col   r_s_col;
    glpf_pkg::t_pixel right_px;

    logic in_acc, cfg_wr, cfg_hit, out_free;
    logic s_r1, s_r2, s_c1, s_c2, s_lr, s_lc, s_flush, s_done;
    logic above_ok, left_ok, self_ok;
    glpf_pkg::t_col_mask bit_cur, mask_new, fl_low, fl_rest;
    glpf_pkg::t_col      fl_idx;

    always_comb begin
        rows_lim = glpf_pkg::size_lim(r_cfg_rows, glpf_pkg::MAX_ROWS);
        cols_lim = glpf_pkg::size_lim(r_cfg_cols, glpf_pkg::MAX_COLS);
        last_row = glpf_pkg::t_row'(rows_lim - 32'd1);
        last_col = glpf_pkg::t_col'(cols_lim - 32'd1);
    end

    // handshakes
    assign out_free      = !r_out_valid || !i_peak_stall;
    assign o_pixel_stall = r_flushing || (r_s_valid && (s_flush || !s_done));
    assign in_acc        = i_pixel_valid && !o_pixel_stall;
    assign o_cfg_ready   = !r_s_valid && !r_flushing;
    assign cfg_wr        = i_cfg_valid && o_cfg_ready;
    assign cfg_hit       = (i_cfg_index == glpf_pkg::CFG_FRAME_ROWS) ||
                           (i_cfg_index == glpf_pkg::CFG_FRAME_COLS);

    assign o_peak_valid = r_out_valid;
    assign o_peak_row   = r_out_row;
    assign o_peak_col   = r_out_col;
    assign o_run_last   = r_out_last;

    // line store, read one column ahead
    assign nxt_col = (r_col == last_col) ? '0 : r_col + glpf_pkg::t_col'(1);
    assign rd_eff  = r_fwd ? r_fwd_data : ram_rd;
    assign wr_data = '{up: i_pixel_value, upup: rd_eff.up};

    glpf_ram #(
        .WIDTH(2 * glpf_pkg::PIXEL_WIDTH),
        .DEPTH(glpf_pkg::MAX_COLS)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (r_col),
        .i_wr_data (wr_data),
        .i_rd_en   (in_acc),
        .i_rd_addr (nxt_col),
        .o_rd_data (ram_rd)
    );

    // decision stage
    assign right_px = rd_eff.up;
    assign s_r1     = r_s_row != '0;
    assign s_r2     = r_s_row > glpf_pkg::t_row'(1);
    assign s_c1     = r_s_col != '0;
    assign s_c2     = r_s_col > glpf_pkg::t_col'(1);
    assign s_lr     = r_s_row == last_row;
    assign s_lc     = r_s_col == last_col;
    assign s_flush  = s_lr && s_lc;

    assign above_ok = s_r1 && (r_s_up >= r_s_x) &&
                      (!s_r2 || (r_s_up >= r_s_upup)) &&
                      (!s_c1 || (r_s_up >= r_s_upl)) &&
                      (s_lc || (r_s_up >= right_px));
    assign left_ok  = s_lr && s_c1 && (r_s_prev0 >= r_s_x) &&
                      (!s_c2 || (r_s_prev0 >= r_s_prev1)) &&
                      (!s_r1 || (r_s_prev0 >= r_s_upl));
    assign self_ok  = s_flush && (!s_c1 || (r_s_x >= r_s_prev0)) &&
                      (!s_r1 || (r_s_x >= r_s_up));

    assign bit_cur  = glpf_pkg::t_col_mask'(1) << r_s_col;
    assign mask_new = r_flags | (left_ok ? (bit_cur >> 1) : '0) |
                      (self_ok ? bit_cur : '0);
    assign s_done   = !above_ok || out_free;

    // final row flush, lowest column first
    assign fl_low  = r_flags & (~r_flags + glpf_pkg::t_col_mask'(1));
    assign fl_rest = r_flags & (r_flags - glpf_pkg::t_col_mask'(1));

    always_comb begin
        fl_idx = '0;
        for (int k = 0; k < glpf_pkg::MAX_COLS; k++) begin
            if (fl_low[k]) begin
                fl_idx = fl_idx | glpf_pkg::t_col'(k);
            end
        end
    end

    always_comb begin
        n_cfg_rows  = r_cfg_rows;
        n_cfg_cols  = r_cfg_cols;
        n_row       = r_row;
        n_col       = r_col;
        n_s_valid   = r_s_valid;
        n_flags     = r_flags;
        n_flushing  = r_flushing;
        n_out_valid = r_out_valid && i_peak_stall;
        n_fwd       = r_fwd;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_last  = r_out_last;

        if (r_s_valid && s_done) begin
            n_s_valid  = 1'b0;
            n_flags    = mask_new;
            n_flushing = s_flush && (mask_new != '0);
            if (above_ok) begin
                n_out_valid = 1'b1;
                n_out_row   = r_s_row - glpf_pkg::t_row'(1);
                n_out_col   = r_s_col;
                n_out_last  = !(s_flush && (mask_new != '0));
            end
        end

        if (r_flushing && out_free) begin
            n_out_valid = 1'b1;
            n_out_row   = last_row;
            n_out_col   = fl_idx;
            n_out_last  = fl_rest == '0;
            n_flags     = fl_rest;
            n_flushing  = fl_rest != '0;
        end

        if (in_acc) begin
            n_s_valid = 1'b1;
            n_fwd     = nxt_col == r_col;
            n_col     = nxt_col;
            if (r_col == last_col) begin
                n_row = (r_row == last_row) ? '0 : r_row + glpf_pkg::t_row'(1);
            end
        end

        if (cfg_wr && cfg_hit) begin
            if (i_cfg_index == glpf_pkg::CFG_FRAME_ROWS) begin
                n_cfg_rows = i_cfg_data;
            end else begin
                n_cfg_cols = i_cfg_data;
            end
            n_row      = '0;
            n_col      = '0;
            n_flags    = '0;
            n_flushing = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows  <= glpf_pkg::t_cfg'(glpf_pkg::MAX_ROWS);
            r_cfg_cols  <= glpf_pkg::t_cfg'(glpf_pkg::MAX_COLS);
            r_row       <= '0;
            r_col       <= '0;
            r_s_valid   <= 1'b0;
            r_flags     <= '0;
            r_flushing  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            r_cfg_rows  <= n_cfg_rows;
            r_cfg_cols  <= n_cfg_cols;
            r_row       <= n_row;
            r_col       <= n_col;
            r_s_valid   <= n_s_valid;
            r_flags     <= n_flags;
            r_flushing  <= n_flushing;
            r_out_valid <= n_out_valid;
            r_fwd       <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_last <= n_out_last;
        if (in_acc) begin
            r_fwd_data <= wr_data;
            r_s_x      <= i_pixel_value;
            r_s_row    <= r_row;
            r_s_col    <= r_col;
            r_s_up     <= rd_eff.up;
            r_s_upup   <= rd_eff.upup;
            r_s_upl    <= r_up_hold;
            r_up_hold  <= rd_eff.up;
            r_s_prev0  <= r_prev0;
            r_s_prev1  <= r_prev1;
            r_prev1    <= r_prev0;
            r_prev0    <= i_pixel_value;
        end
    end

endmodule
